/* rtl/longest_unique_substring_length_top_defines.svh */
// Assertion macros for the longest unique substring length block.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LONGEST_UNIQUE_SUBSTRING_LENGTH_TOP_DEFINES_SVH
`define LONGEST_UNIQUE_SUBSTRING_LENGTH_TOP_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising clk edge outside reset.
`define LUSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is never seen outside reset.
`define LUSL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LUSL_ASSERT(label, prop, msg)
`define LUSL_NEVER(label, cond, msg)
`endif

`endif

/* rtl/lusl_pkg.sv */
// Shared constants and types for the longest unique substring length block.
// No dependencies; imported by the table and the top level.
`timescale 1ns / 1ps

package lusl_pkg;

  // String and alphabet limits
  localparam int unsigned MAX_LEN  = 65536;
  localparam int unsigned ALPHABET = 256;

  // Field and state widths
  localparam int unsigned SYM_W = 8;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned POS_W = 16;

  localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);

  // Write port of the position table
  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    logic [POS_W-1:0] pos;
  } lusl_wr_t;

  // Lookup result for the symbol in the compute stage
  typedef struct packed {
    logic             seen;
    logic [POS_W-1:0] pos;
  } lusl_look_t;

endpackage

/* rtl/lusl_table.sv */
// Last-seen position table: one synchronous RAM plus per-symbol valid flops.
// Depends on lusl_pkg; forwards a write that lands on the edge of a read.
`timescale 1ns / 1ps

module lusl_table import lusl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [SYM_W-1:0] rd_addr,
  input  lusl_wr_t         wr,
  input  logic             clr,
  input  logic [SYM_W-1:0] lk_sym,
  output lusl_look_t       look
);

  logic [POS_W-1:0]    pos_mem [ALPHABET];
  logic [POS_W-1:0]    rdata_r;
  logic [POS_W-1:0]    fwd_r;
  logic                hit_r;
  logic [ALPHABET-1:0] seen_r;

  // Write and registered read of the position memory
  always_ff @(posedge clk) begin
    if (wr.en) begin
      pos_mem[wr.addr] <= wr.pos;
    end
    if (rd_en) begin
      rdata_r <= pos_mem[rd_addr];
      fwd_r   <= wr.pos;
    end
  end

  // Note a write to the same entry on the read edge; the RAM returns old data then
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= wr.en && (wr.addr == rd_addr);
    end
  end

  // Valid bits: drop all at end of string, set on each write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (clr) begin
      seen_r <= '0;
    end else if (wr.en) begin
      seen_r[wr.addr] <= 1'b1;
    end
  end

  assign look.seen = seen_r[lk_sym];
  assign look.pos  = hit_r ? fwd_r : rdata_r;

endmodule

/* rtl/longest_unique_substring_length_top.sv */
// Top level of the longest unique substring length block.
// Depends on lusl_pkg, lusl_table and the assertion macro header.
//
// Usage: the string arrives on the in_ channel one byte per item, with
// in_is_last high on its final byte. Each byte looks up the last position of
// its value in a 256-entry RAM; the read is issued when the item is accepted
// and the window update and write-back happen when it leaves the compute stage.
// Throughput: one item per cycle while the compute stage is not stalled. The
// single RAM read-modify-write per byte sets this figure; a write that meets a
// read of the same entry is forwarded. A string's result is registered when its
// final byte leaves the compute stage and appears in the cycle after that stage.
// Only the final byte yields an item: out_longest_length (1..65536) and
// out_too_long, set when the string held more than 65536 bytes (later bytes
// are ignored apart from setting that flag). State clears after each string.
// Reset (rst_n low, synchronous) clears the valid bits, the window state and
// the pipeline; the RAM contents need no clearing pass.
// Stall: the result waits in an output register; further bytes keep flowing
// until a second final byte reaches the compute stage while it still waits.
`timescale 1ns / 1ps

`include "longest_unique_substring_length_top_defines.svh"

module longest_unique_substring_length_top import lusl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] in_data_byte,
  input  logic             in_is_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LEN_W-1:0] out_longest_length,
  output logic             out_too_long
);

  logic             s1_valid_r;
  logic [SYM_W-1:0] s1_sym_r;
  logic             s1_last_r;
  logic             s1_adv;
  logic             s1_fire;
  logic             in_acc;

  logic [LEN_W-1:0] wb_r,   wb_nxt;
  logic [LEN_W-1:0] pos_r,  pos_nxt;
  logic [LEN_W-1:0] best_r, best_nxt;
  logic             ovf_r,  ovf_nxt;

  logic             out_valid_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_tl_r;

  logic             full;
  logic             in_win;
  logic [LEN_W-1:0] wb_new;
  logic [LEN_W-1:0] run;
  logic [LEN_W-1:0] best_new;
  logic [LEN_W-1:0] res_len;
  logic             res_tl;

  lusl_wr_t   wr;
  lusl_look_t look;

  // Handshake: the compute stage stalls only when a result cannot be stored
  assign s1_adv   = !(s1_last_r && out_valid_r && !out_ready);
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  lusl_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_data_byte),
    .wr      (wr),
    .clr     (s1_fire && s1_last_r),
    .lk_sym  (s1_sym_r),
    .look    (look)
  );

  // Capture the accepted item for the compute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r  <= in_data_byte;
      s1_last_r <= in_is_last;
    end
  end

  // Window update for the byte in the compute stage
  assign full     = (pos_r >= MAX_LEN_V);
  assign in_win   = look.seen && ({1'b0, look.pos} >= wb_r);
  assign wb_new   = in_win ? ({1'b0, look.pos} + LEN_W'(1)) : wb_r;
  assign run      = pos_r - wb_new + LEN_W'(1);
  assign best_new = (run > best_r) ? run : best_r;

  assign wr.en    = s1_fire && !full;
  assign wr.addr  = s1_sym_r;
  assign wr.pos   = pos_r[POS_W-1:0];

  assign res_len  = full ? best_r : best_new;
  assign res_tl   = full || ovf_r;

  // Advance the string state; clear it after the final byte
  always_comb begin
    wb_nxt   = wb_r;
    pos_nxt  = pos_r;
    best_nxt = best_r;
    ovf_nxt  = ovf_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        wb_nxt   = '0;
        pos_nxt  = '0;
        best_nxt = '0;
        ovf_nxt  = 1'b0;
      end else if (full) begin
        ovf_nxt  = 1'b1;
      end else begin
        wb_nxt   = wb_new;
        pos_nxt  = pos_r + LEN_W'(1);
        best_nxt = best_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r   <= '0;
      pos_r  <= '0;
      best_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      wb_r   <= wb_nxt;
      pos_r  <= pos_nxt;
      best_r <= best_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_len_r <= res_len;
      out_tl_r  <= res_tl;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_longest_length = out_len_r;
  assign out_too_long       = out_tl_r;

  // Checks on the window state and the result path
  `LUSL_NEVER(a_pos_bound, pos_r > MAX_LEN_V, "position beyond MAX_LEN")
  `LUSL_NEVER(a_order, (wb_r > pos_r) || (best_r > pos_r), "window state out of order")
  `LUSL_ASSERT(a_result_loaded, (s1_fire && s1_last_r) |=> out_valid, "final byte gave no item")
  `LUSL_ASSERT(a_len_nonzero, out_valid |-> (out_longest_length != '0), "zero length result")

endmodule

/* test/tb_top.sv */
// Testbench for longest_unique_substring_length_top: streams byte strings and scores each result.
// Depends on lusl_pkg and the RTL top level; expected values: built-in predictor or directed table.
`timescale 1ns / 1ps

module tb_top;
  import lusl_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 850;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             too_long;
  } run_result_t;

  typedef struct packed {
    logic [SYM_W-1:0] data_byte;
    logic             is_last;
    logic             typed;
    logic [LEN_W-1:0] len;
    logic             too_long;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [SYM_W-1:0] in_data_byte = '0;
  logic             in_is_last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [LEN_W-1:0] out_longest_length;
  logic             out_too_long;

  bit          in_fire;
  bit          out_fire;
  bit          quiet;
  int          mismatch_count;
  int unsigned cycle_count;
  run_result_t pending_runs[$];

  // Window predictor state
  bit          sym_seen [ALPHABET];
  int unsigned sym_last [ALPHABET];
  int unsigned win_start;
  int unsigned byte_count;
  int unsigned best_run;
  bit          overflow;

  // Directed strings: single bytes, back-to-back repeats, a window that must not move back
  dir_row_t dir_rows [23] = '{
    '{8'h00, 1'b1, 1'b1, 17'd1, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 17'd1, 1'b0},
    '{8'h41, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h41, 1'b1, 1'b1, 17'd1, 1'b0},
    '{8'h61, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h63, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h61, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h63, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h62, 1'b1, 1'b1, 17'd3, 1'b0},
    '{8'h61, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h61, 1'b1, 1'b1, 17'd2, 1'b0},
    '{8'h55, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h7F, 1'b1, 1'b0, 17'd0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 17'd0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 17'd2, 1'b0}
  };

  longest_unique_substring_length_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_longest_length (out_longest_length),
    .out_too_long       (out_too_long)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function void clear_string();
    foreach (sym_seen[i]) sym_seen[i] = 1'b0;
    win_start  = 0;
    byte_count = 0;
    best_run   = 0;
    overflow   = 1'b0;
  endfunction

  // Advance the distinct-byte window by one byte; return 1 with the run on the final byte
  function bit advance_window(input logic [SYM_W-1:0] b, input logic last,
                              output run_result_t run);
    int unsigned cur;
    run = '0;
    if (byte_count >= MAX_LEN) begin
      overflow = 1'b1;
    end else begin
      if (sym_seen[b] && sym_last[b] >= win_start) win_start = sym_last[b] + 1;
      sym_last[b] = byte_count;
      sym_seen[b] = 1'b1;
      cur = byte_count - win_start + 1;
      if (cur > best_run) best_run = cur;
      byte_count++;
    end
    if (!last) return 1'b0;
    run.len      = LEN_W'((best_run > MAX_LEN) ? MAX_LEN : best_run);
    run.too_long = overflow;
    clear_string();
    return 1'b1;
  endfunction

  // Offer one item, hold it until accepted, then record the expected result if it ends a string
  task automatic send_byte(input logic [SYM_W-1:0] b, input logic last,
                           input bit typed, input run_result_t typed_run);
    int          gap;
    run_result_t run;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_is_last   <= last;
    do @(posedge clk); while (!in_fire);
    if (advance_window(b, last, run)) pending_runs = {pending_runs, (typed ? typed_run : run)};
  endtask

  // Sample both handshakes mid-cycle and score results
  always @(negedge clk) begin
    run_result_t exp_run;
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (out_fire) begin
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual length %0d too_long %0b",
                 $time, out_longest_length, out_too_long);
        mismatch_count++;
      end else begin
        exp_run = pending_runs.pop_front();
        if (out_longest_length !== exp_run.len) begin
          $display("%0t: longest_length expected %0d actual %0d",
                   $time, exp_run.len, out_longest_length);
          mismatch_count++;
        end
        if (out_too_long !== exp_run.too_long) begin
          $display("%0t: too_long expected %0b actual %0b",
                   $time, exp_run.too_long, out_too_long);
          mismatch_count++;
        end
      end
    end
  end

  // Stall the result side at random
  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [SYM_W-1:0] str[$];
    logic [SYM_W-1:0] perm [ALPHABET];
    logic [SYM_W-1:0] tmp;
    logic [SYM_W-1:0] base;
    int sent;
    int mode;
    int len;
    int j;

    clear_string();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data_byte, dir_rows[i].is_last, dir_rows[i].typed,
                '{dir_rows[i].len, dir_rows[i].too_long});
    end

    // Random strings: wide random, narrow alphabet, and long permutations
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      str.delete();
      mode  = $urandom_range(0, 19);
      quiet = ($urandom_range(0, 9) == 0);
      if (mode < 9) begin
        len = $urandom_range(1, 16);
        repeat (len) str = {str, SYM_W'($urandom)};
      end else if (mode < 18) begin
        len  = $urandom_range(1, 30);
        base = SYM_W'($urandom);
        repeat (len) str = {str, base + SYM_W'($urandom_range(0, 5))};
      end else begin
        foreach (perm[i]) perm[i] = SYM_W'(i);
        for (int i = ALPHABET - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        len = $urandom_range(240, 300);
        for (int i = 0; i < len; i++) str = {str, perm[i % ALPHABET]};
      end
      foreach (str[i]) send_byte(str[i], i == str.size() - 1, 1'b0, '0);
      sent += str.size();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding results
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
